// ===== rtl/lkdc_pkg.sv =====
// Shared types, constants and helper functions for the LCG keystream descrambler.
// No dependencies; used by every module of the block by scoped names.
package lkdc_pkg;

	localparam logic [3:0]  HDR_BYTES   = 4'd12;
	localparam logic [3:0]  MAGIC_BYTES = 4'd4;
	localparam logic [3:0]  SUM_END     = 4'd8;
	localparam logic [31:0] LCG_MUL     = 32'd69069;
	localparam logic [31:0] LCG_INC     = 32'd1;
	localparam logic [31:0] ROT_TEST    = 32'h0000_0110;
	localparam int          KEY_W       = 15;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_SHORT     = 2'd1;
	localparam logic [1:0] ST_BAD_MAGIC = 2'd2;
	localparam logic [1:0] ST_MISMATCH  = 2'd3;

	typedef struct packed {
		logic       emit;
		logic [7:0] data;
		logic       data_valid;
		logic       done;
		logic [1:0] status;
	} res_t;

	// Expected magic byte at a header position ("JPMH").
	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd0: b = 8'h4A;
			2'd1: b = 8'h50;
			2'd2: b = 8'h4D;
			2'd3: b = 8'h48;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Sign-extend a decoded word, xor it in, then rotate by one.
	function automatic logic [31:0] fold_word(input logic [31:0] sum, input logic [15:0] w);
		logic [31:0] s;
		s = sum ^ {{16{w[15]}}, w};
		if ((s & ROT_TEST) != 32'd0)
			return {s[30:0], s[31]};
		else
			return {s[0], s[31:1]};
	endfunction

endpackage

// ===== rtl/lkdc_keygen.sv =====
// Keystream generator step: advance the 69069 LCG once and pick the 15-bit word key.
// Depends on lkdc_pkg.
module lkdc_keygen (
	input  logic [31:0]                    gen_cur,
	output logic [31:0]                    gen_next,
	output logic [lkdc_pkg::KEY_W-1:0]     key_next
);

	logic [31:0] prod;

	assign prod     = gen_cur * lkdc_pkg::LCG_MUL;
	assign gen_next = prod + lkdc_pkg::LCG_INC;
	assign key_next = gen_next[lkdc_pkg::KEY_W+7:8];

endmodule

// ===== rtl/lkdc_step.sv =====
// Per-byte file state: header parse, word descramble, checksum fold and final status.
// Depends on lkdc_pkg and lkdc_keygen.
module lkdc_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          byte_s1,
	input  logic                last_s1,
	output lkdc_pkg::res_t      res
);

	logic [3:0]                    hdr_pos_q;
	logic                          magic_good_q;
	logic [31:0]                   stored_sum_q;
	logic [31:0]                   gen_q;
	logic [lkdc_pkg::KEY_W-1:0]    key_q;
	logic                          high_next_q;
	logic [7:0]                    pend_q;
	logic [31:0]                   sum_q;

	logic [31:0]                   gen_next;
	logic [lkdc_pkg::KEY_W-1:0]    key_next;
	logic                          in_hdr;
	logic                          in_magic;
	logic                          magic_n;
	logic [3:0]                    pos_n;
	logic [7:0]                    dec_lo;
	logic [7:0]                    dec_hi;
	logic [7:0]                    dec;
	logic [31:0]                   sum_fold;
	logic [31:0]                   sum_n;
	logic                          pay_valid;

	lkdc_keygen u_keygen (
		.gen_cur  (gen_q),
		.gen_next (gen_next),
		.key_next (key_next)
	);

	assign in_hdr   = hdr_pos_q < lkdc_pkg::HDR_BYTES;
	assign in_magic = hdr_pos_q < lkdc_pkg::MAGIC_BYTES;
	assign magic_n  = magic_good_q &
		(!in_magic || (byte_s1 == lkdc_pkg::magic_byte(hdr_pos_q[1:0])));
	assign pos_n    = in_hdr ? hdr_pos_q + 4'd1 : hdr_pos_q;

	assign dec_lo   = byte_s1 ^ key_next[7:0];
	assign dec_hi   = byte_s1 ^ {1'b0, key_q[lkdc_pkg::KEY_W-1:8]};
	assign dec      = high_next_q ? dec_hi : dec_lo;
	assign sum_fold = lkdc_pkg::fold_word(sum_q, {dec_hi, pend_q});
	assign sum_n    = (!in_hdr && high_next_q) ? sum_fold : sum_q;
	assign pay_valid = !in_hdr && magic_good_q;

	always_comb begin
		res            = '0;
		res.emit       = pay_valid || last_s1;
		res.data_valid = pay_valid;
		res.data       = pay_valid ? dec : 8'h00;
		res.done       = last_s1;
		if (last_s1) begin
			if (pos_n < lkdc_pkg::HDR_BYTES)
				res.status = lkdc_pkg::ST_SHORT;
			else if (!magic_n)
				res.status = lkdc_pkg::ST_BAD_MAGIC;
			else if (sum_n != stored_sum_q)
				res.status = lkdc_pkg::ST_MISMATCH;
			else
				res.status = lkdc_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q    <= '0;
			magic_good_q <= 1'b1;
			stored_sum_q <= '0;
			gen_q        <= '0;
			key_q        <= '0;
			high_next_q  <= 1'b0;
			pend_q       <= '0;
			sum_q        <= '0;
		end else if (fire) begin
			if (last_s1) begin
				// end of file: start clean for the next one
				hdr_pos_q    <= '0;
				magic_good_q <= 1'b1;
				stored_sum_q <= '0;
				gen_q        <= '0;
				key_q        <= '0;
				high_next_q  <= 1'b0;
				pend_q       <= '0;
				sum_q        <= '0;
			end else if (in_hdr) begin
				hdr_pos_q    <= pos_n;
				magic_good_q <= magic_n;
				if (!in_magic && hdr_pos_q < lkdc_pkg::SUM_END)
					stored_sum_q <= {byte_s1, stored_sum_q[31:8]};
				else if (!in_magic)
					gen_q <= {byte_s1, gen_q[31:8]};
			end else if (!high_next_q) begin
				gen_q       <= gen_next;
				key_q       <= key_next;
				pend_q      <= dec_lo;
				high_next_q <= 1'b1;
			end else begin
				sum_q       <= sum_fold;
				high_next_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/lcg_keystream_descrambler_checksum_core.sv =====
// Top level of the LCG keystream descrambler with rotating checksum.
// Depends on lkdc_pkg and lkdc_step (which instantiates lkdc_keygen).
//
// A scrambled file enters one byte per request, header first, with in_last on its
// final byte. The 12-byte header carries the magic "JPMH", a little-endian stored
// checksum and a little-endian 32-bit seed; header bytes give no result except when
// marked last. Each payload byte gives one result with byte_valid set while the magic
// is good; on a bad magic payload is dropped. The result for the last byte has
// done_res set and a status: 0 ok, 1 too short, 2 bad magic, 3 checksum mismatch.
// After the last byte all state returns to reset, so the next byte opens a new file.
// Timing: the block takes one byte per cycle while the consumer does not stall. A byte
// is held in the input register, is processed by one pass of logic (one 32-bit constant
// multiply for the generator, xor, checksum fold) and its result is loaded into the
// output register when the byte advances out of the input register. The input register
// advances whenever the output register is empty or being drained in the same cycle;
// a result held by a stalled consumer holds the input register and thus the input.
module lcg_keystream_descrambler_checksum_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       done_res,
	output logic [1:0] status
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       byte_valid_q;
	logic       done_q;
	logic [1:0] status_q;

	logic           adv;
	lkdc_pkg::res_t res;

	// advance the held request when the output slot is free or draining now
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	lkdc_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (adv),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.res     (res)
	);

	// load a result only when the request produces one; otherwise drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			out_byte_q   <= res.data;
			byte_valid_q <= res.data_valid;
			done_q       <= res.done;
			status_q     <= res.status;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign done_res   = done_q;
	assign status     = status_q;

	// a result that does not close a file always carries a payload byte
	a_mid_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> byte_valid)
		else $error("mid-file result without payload byte");

	// status is only reported on the closing result
	a_mid_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> status == lkdc_pkg::ST_OK)
		else $error("status set on mid-file result");

	// bad magic or too short suppresses the payload byte
	a_err_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res &&
		(status == lkdc_pkg::ST_BAD_MAGIC || status == lkdc_pkg::ST_SHORT) |-> !byte_valid)
		else $error("payload byte on suppressed result");

	// a held request is not lost while the output stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input register lost a stalled request");

endmodule

// ===== test/tb_lcg_keystream_descrambler_checksum_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for lcg_keystream_descrambler_checksum_core: sends scrambled files,
// predicts every decoded byte and closing status, and checks results under random stalls.
// Depends on lkdc_pkg and the core RTL.
module tb_lcg_keystream_descrambler_checksum_core;

	typedef enum int {
		FILE_CLEAN,
		FILE_BAD_MAGIC,
		FILE_BAD_SUM,
		FILE_TRUNCATED
	} file_kind_t;

	typedef logic [7:0] octet_q_t [$];

	typedef struct packed {
		logic [7:0] data;
		logic       dv;
		logic       done;
		logic [1:0] st;
	} decode_t;

	// "JPMH" laid out so that byte i of the file is bits [8*i +: 8].
	localparam logic [31:0] MAGIC_LE = 32'h484D_504A;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] in_byte   = 8'h00;
	logic       in_last   = 1'b0;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       done_res;
	logic [1:0] status;

	// Descrambler state as the block should hold it.
	logic [3:0]  hdr_pos;
	logic        magic_ok;
	logic [31:0] want_sum;
	logic [31:0] lcg;
	logic [14:0] key;
	logic        odd_half;
	logic [7:0]  low_byte;
	logic [31:0] cur_sum;

	decode_t expected_decodes [$];
	int      err_count  = 0;
	int      bytes_sent = 0;
	bit      tx_calm    = 1'b0;
	bit      rx_calm    = 1'b0;
	int      rx_hold    = 0;

	lcg_keystream_descrambler_checksum_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.byte_valid(byte_valid),
		.done_res  (done_res),
		.status    (status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mostly back to back, sometimes a short gap, rarely a long one.
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 24);
	endfunction

	// Xor in the sign-extended word, then rotate by one in the direction the bit test picks.
	function automatic logic [31:0] rotate_fold(input logic [31:0] acc, input logic [15:0] w);
		logic [31:0] s;
		s = acc ^ {{16{w[15]}}, w};
		if ((s & lkdc_pkg::ROT_TEST) != 32'd0)
			return {s[30:0], s[31]};
		else
			return {s[0], s[31:1]};
	endfunction

	// Checksum a well-formed payload would carry, used to build files that should pass.
	function automatic logic [31:0] payload_checksum(input logic [31:0] seed,
			input octet_q_t pay);
		logic [31:0] g;
		logic [31:0] acc;
		logic [14:0] k;
		g = seed;
		acc = 32'd0;
		for (int i = 0; i + 1 < pay.size(); i += 2) begin
			g = g * lkdc_pkg::LCG_MUL + lkdc_pkg::LCG_INC;
			k = g[8 +: lkdc_pkg::KEY_W];
			acc = rotate_fold(acc, {pay[i + 1] ^ {1'b0, k[14:8]}, pay[i] ^ k[7:0]});
		end
		return acc;
	endfunction

	function automatic octet_q_t random_payload(input int len);
		octet_q_t q;
		for (int i = 0; i < len; i++)
			q.push_back(8'($urandom));
		return q;
	endfunction

	task automatic clear_model();
		hdr_pos  = 4'd0;
		magic_ok = 1'b1;
		want_sum = 32'd0;
		lcg      = 32'd0;
		key      = 15'd0;
		odd_half = 1'b0;
		low_byte = 8'h00;
		cur_sum  = 32'd0;
	endtask

	// Advance the model by one accepted request and queue the result it causes, if any.
	task automatic descramble_model(input logic [7:0] value, input logic is_last);
		decode_t    r;
		logic       emit;
		logic [7:0] dec;
		r = '0;
		emit = 1'b0;
		if (hdr_pos < lkdc_pkg::HDR_BYTES) begin
			if (hdr_pos < lkdc_pkg::MAGIC_BYTES) begin
				if (value != MAGIC_LE[8 * hdr_pos[1:0] +: 8])
					magic_ok = 1'b0;
			end else if (hdr_pos < lkdc_pkg::SUM_END) begin
				want_sum = {value, want_sum[31:8]};
			end else begin
				lcg = {value, lcg[31:8]};
			end
			hdr_pos = hdr_pos + 4'd1;
		end else begin
			if (!odd_half) begin
				lcg = lcg * lkdc_pkg::LCG_MUL + lkdc_pkg::LCG_INC;
				key = lcg[8 +: lkdc_pkg::KEY_W];
				dec = value ^ key[7:0];
				low_byte = dec;
				odd_half = 1'b1;
			end else begin
				dec = value ^ {1'b0, key[14:8]};
				cur_sum = rotate_fold(cur_sum, {dec, low_byte});
				odd_half = 1'b0;
			end
			if (magic_ok) begin
				r.data = dec;
				r.dv = 1'b1;
				emit = 1'b1;
			end
		end
		if (is_last) begin
			emit = 1'b1;
			r.done = 1'b1;
			if (hdr_pos < lkdc_pkg::HDR_BYTES) begin
				r.st = lkdc_pkg::ST_SHORT;
				r.data = 8'h00;
				r.dv = 1'b0;
			end else if (!magic_ok) begin
				r.st = lkdc_pkg::ST_BAD_MAGIC;
			end else if (cur_sum != want_sum) begin
				r.st = lkdc_pkg::ST_MISMATCH;
			end else begin
				r.st = lkdc_pkg::ST_OK;
			end
			clear_model();
		end
		if (emit)
			expected_decodes.push_back(r);
	endtask

	task automatic note_error(input string msg);
		err_count++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	task automatic check_result();
		decode_t e;
		if (expected_decodes.size() == 0) begin
			note_error($sformatf("result with nothing pending: byte %02h valid %0b done %0b st %0d",
				out_byte, byte_valid, done_res, status));
		end else begin
			e = expected_decodes.pop_front();
			if (out_byte !== e.data)
				note_error($sformatf("out_byte %02h, want %02h", out_byte, e.data));
			if (byte_valid !== e.dv)
				note_error($sformatf("byte_valid %0b, want %0b", byte_valid, e.dv));
			if (done_res !== e.done)
				note_error($sformatf("done_res %0b, want %0b", done_res, e.done));
			if (status !== e.st)
				note_error($sformatf("status %0d, want %0d", status, e.st));
		end
	endtask

	// Take results and stall the output side at random.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_result();
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else begin
			out_ready <= 1'b1;
			if (!rx_calm)
				rx_hold = idle_span();
		end
	end

	// Present one request and hold it until the block takes it. Valid stays high into the
	// next request when there is no gap, so it is never lowered and raised in one step.
	task automatic send_byte(input logic [7:0] value, input logic is_last);
		int gap;
		gap = tx_calm ? 0 : idle_span();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= value;
		in_last  <= is_last;
		descramble_model(value, is_last);
		bytes_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and hold off until every pending result has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_decodes.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Build header plus payload, spoil it as asked, and send it with the last mark on its end.
	task automatic send_file(input logic [31:0] seed, input octet_q_t pay,
			input file_kind_t kind);
		octet_q_t    raw;
		logic [31:0] chk;
		int          cut;
		chk = payload_checksum(seed, pay);
		if (kind == FILE_BAD_SUM)
			chk = chk ^ (32'd1 << $urandom_range(0, 31));
		for (int i = 0; i < 4; i++)
			raw.push_back(MAGIC_LE[8 * i +: 8]);
		if (kind == FILE_BAD_MAGIC) begin
			cut = $urandom_range(0, 3);
			raw[cut] = raw[cut] ^ 8'($urandom_range(1, 255));
		end
		for (int i = 0; i < 4; i++)
			raw.push_back(chk[8 * i +: 8]);
		for (int i = 0; i < 4; i++)
			raw.push_back(seed[8 * i +: 8]);
		for (int i = 0; i < pay.size(); i++)
			raw.push_back(pay[i]);
		if (kind == FILE_TRUNCATED) begin
			cut = $urandom_range(1, 11);
			while (raw.size() > cut)
				void'(raw.pop_back());
		end
		for (int i = 0; i < raw.size(); i++)
			send_byte(raw[i], i == raw.size() - 1);
	endtask

	// Extremes and the closing cases that need no long file.
	task automatic test_directed();
		octet_q_t pay;
		// last mark on the very first byte: too short
		send_byte(8'h00, 1'b1);
		// wrong magic in a three-byte file: too short still wins
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		// all-ones seed, one full word and a trailing odd byte that stays out of the sum
		pay.push_back(8'h00);
		pay.push_back(8'hFF);
		pay.push_back(8'hFF);
		send_file(32'hFFFF_FFFF, pay, FILE_CLEAN);
	endtask

	// Whole files with random content, mostly well formed, with calm stretches mixed in.
	task automatic test_file_stream(input int byte_budget);
		int         stop_at;
		int         r;
		int         len;
		file_kind_t kind;
		stop_at = bytes_sent + byte_budget;
		while (bytes_sent < stop_at) begin
			r = $urandom_range(0, 9);
			tx_calm = (r == 0) || (r == 1);
			rx_calm = (r == 0) || (r == 2);
			r = $urandom_range(0, 99);
			if (r < 70)
				kind = FILE_CLEAN;
			else if (r < 80)
				kind = FILE_BAD_SUM;
			else if (r < 90)
				kind = FILE_BAD_MAGIC;
			else
				kind = FILE_TRUNCATED;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
			send_file($urandom, random_payload(len), kind);
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// Raw bytes with stray last marks, closed by a last so the next file starts clean.
	task automatic test_line_noise(input int count);
		for (int i = 0; i < count; i++)
			send_byte(8'($urandom), $urandom_range(0, 19) == 0);
		send_byte(8'($urandom), 1'b1);
	endtask

	// Let the block run dry between files.
	task automatic test_drain_pause(input int files);
		for (int i = 0; i < files; i++) begin
			send_file($urandom, random_payload($urandom_range(0, 16)), FILE_CLEAN);
			wait_idle();
		end
	endtask

	initial begin
		clear_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_idle();
		test_file_stream(460);
		test_line_noise(120);
		test_drain_pause(4);
		test_file_stream(100);
		wait_idle();
		if (err_count == 0)
			$display("tb_lcg_keystream_descrambler_checksum_core OK");
		else
			$display("tb_lcg_keystream_descrambler_checksum_core NOT OK");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("tb_lcg_keystream_descrambler_checksum_core NOT OK");
		$finish;
	end

endmodule
